@@ rtl/qmd_pkg.sv @@
// Shared types and constants for the quadrotor motor mixer with desaturation.
package qmd_pkg;

	// Q2.14 unit and minimum usable headroom (0.01)
	localparam logic [14:0]        Q_ONE     = 15'd16384;
	localparam logic signed [15:0] TQ_POS    = 16'sd16384;
	localparam logic signed [15:0] TQ_NEG    = -16'sd16384;
	localparam logic [13:0]        MIN_HEAD  = 14'd164;

	// Divider geometry: quotient never exceeds the headroom (at most 8192)
	localparam int QW = 14;
	localparam int NW = 28;

	// Path taken by a request through the mixer
	typedef enum logic [1:0] {
		MODE_FLAT,
		MODE_SCALE,
		MODE_PASS
	} mode_t;

	typedef struct packed {
		logic signed [15:0] roll_torque;
		logic signed [15:0] pitch_torque;
		logic signed [15:0] yaw_torque;
		logic signed [15:0] throttle;
	} cmd_t;

	typedef struct packed {
		logic [14:0] motor1_thrust;
		logic [14:0] motor2_thrust;
		logic [14:0] motor3_thrust;
		logic [14:0] motor4_thrust;
	} thrust_t;

	// Values that ride alongside the divider
	typedef struct packed {
		mode_t              mode;
		logic [14:0]        thr;
		logic               neg_r;
		logic               neg_p;
		logic signed [15:0] r_pass;
		logic signed [15:0] p_pass;
		logic signed [15:0] y_fin;
	} side_t;

	// Contents of one divider cell
	typedef struct packed {
		logic [NW-1:0] rem_r;
		logic [NW-1:0] rem_p;
		logic [QW-1:0] quo_r;
		logic [QW-1:0] quo_p;
		logic [15:0]   den;
		side_t         side;
	} div_t;

endpackage

@@ rtl/quad_motor_mixer_desaturate.sv @@
// Top level of the quadrotor X-frame motor mixer with desaturation.
// A request (start high while busy is low) is taken every clock cycle; busy
// never rises. Each request gives one set of four motor thrusts on thrust,
// marked by done for one cycle, after it has passed through the pipeline:
// two front stages (clamp and headroom, then case choice and dividend
// products), a row of 14 divider cells that each settle one quotient bit of
// the roll and pitch scaling, and one output stage. The receiver cannot hold
// results off; every result appears once and must be taken in that cycle.
module quad_motor_mixer_desaturate import qmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output thrust_t thrust
);

	localparam int LAT = QW + 3;

	logic vld_c [0:QW];
	div_t div_c [0:QW];

	// Always ready for the next request
	assign busy = 1'b0;

	qmd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start && !busy),
		.cmd     (cmd),
		.vld_out (vld_c[0]),
		.div_out (div_c[0])
	);

	// Divider row, most significant quotient bit first
	for (genvar i = 0; i < QW; i++) begin : g_cell
		qmd_div_cell #(
			.BIT (QW - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[i]),
			.div_in  (div_c[i]),
			.vld_out (vld_c[i+1]),
			.div_out (div_c[i+1])
		);
	end

	qmd_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_c[QW]),
		.div_in (div_c[QW]),
		.done   (done),
		.thrust (thrust)
	);

	// Every accepted request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted request gave no result at the expected cycle");

	// No result without a request accepted the latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching request");

	// The last divider cell feeds the output stage
	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[QW] |=> done)
		else $error("divider output did not reach the result stage");

	// Thrusts stay within 0..1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (thrust.motor1_thrust <= Q_ONE) && (thrust.motor2_thrust <= Q_ONE)
			&& (thrust.motor3_thrust <= Q_ONE) && (thrust.motor4_thrust <= Q_ONE))
		else $error("motor thrust above full scale");

endmodule

@@ rtl/qmd_front.sv @@
// Front end: clamp, headroom, case selection and dividend products.
module qmd_front import qmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  cmd_t cmd,
	output logic vld_out,
	output div_t div_out
);

	logic signed [15:0] r_c, p_c, y_c;
	logic [14:0]        t_c, up_c;
	logic [13:0]        h_c;

	logic               vld_s1;
	logic signed [15:0] r_s1, p_s1, y_s1;
	logic [14:0]        t_s1;
	logic [13:0]        h_s1;

	logic [14:0]        ar, ap, ay;
	logic [15:0]        s_sum;
	logic [13:0]        yl;
	logic signed [15:0] yl_s;
	logic [28:0]        prod_r, prod_p;
	logic               flat, scale;
	div_t               div_d;

	logic               vld_s2;
	div_t               div_s2;

	// Clamp the torques and the throttle, form the headroom
	always_comb begin
		r_c = (cmd.roll_torque < TQ_NEG) ? TQ_NEG :
		      (cmd.roll_torque > TQ_POS) ? TQ_POS : cmd.roll_torque;
		p_c = (cmd.pitch_torque < TQ_NEG) ? TQ_NEG :
		      (cmd.pitch_torque > TQ_POS) ? TQ_POS : cmd.pitch_torque;
		y_c = (cmd.yaw_torque < TQ_NEG) ? TQ_NEG :
		      (cmd.yaw_torque > TQ_POS) ? TQ_POS : cmd.yaw_torque;
		if (cmd.throttle[15]) begin
			t_c = '0;
		end else if (cmd.throttle > TQ_POS) begin
			t_c = Q_ONE;
		end else begin
			t_c = cmd.throttle[14:0];
		end
		up_c = Q_ONE - t_c;
		h_c  = (up_c < t_c) ? up_c[13:0] : t_c[13:0];
	end

	// Hold the clamped request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_c;
		p_s1 <= p_c;
		y_s1 <= y_c;
		t_s1 <= t_c;
		h_s1 <= h_c;
	end

	// Pick the case, settle yaw and build the dividends
	always_comb begin
		ar     = r_s1[15] ? 15'(-r_s1) : r_s1[14:0];
		ap     = p_s1[15] ? 15'(-p_s1) : p_s1[14:0];
		ay     = y_s1[15] ? 15'(-y_s1) : y_s1[14:0];
		s_sum  = {1'b0, ar} + {1'b0, ap};
		flat   = h_s1 < MIN_HEAD;
		scale  = s_sum > {2'b0, h_s1};
		yl     = h_s1 - s_sum[13:0];
		yl_s   = $signed({2'b0, yl});
		prod_r = 29'(ar) * 29'(h_s1);
		prod_p = 29'(ap) * 29'(h_s1);

		div_d             = '0;
		div_d.rem_r       = prod_r[NW-1:0];
		div_d.rem_p       = prod_p[NW-1:0];
		div_d.den         = s_sum;
		div_d.side.thr    = t_s1;
		div_d.side.neg_r  = r_s1[15];
		div_d.side.neg_p  = p_s1[15];
		div_d.side.r_pass = r_s1;
		div_d.side.p_pass = p_s1;
		div_d.side.y_fin  = y_s1;
		if (flat) begin
			div_d.side.mode = MODE_FLAT;
		end else if (scale) begin
			div_d.side.mode  = MODE_SCALE;
			div_d.side.y_fin = '0;
		end else begin
			div_d.side.mode = MODE_PASS;
			// yaw scaled by left/|yaw| lands exactly on the headroom left
			if (ay > {1'b0, yl} && ay >= {1'b0, MIN_HEAD}) begin
				div_d.side.y_fin = y_s1[15] ? -yl_s : yl_s;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s2 <= div_d;
	end

	assign vld_out = vld_s2;
	assign div_out = div_s2;

endmodule

@@ rtl/qmd_div_cell.sv @@
// One restoring divider cell: settles one quotient bit of both lanes.
module qmd_div_cell import qmd_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  div_t div_in,
	output logic vld_out,
	output div_t div_out
);

	localparam int CW = NW + 1;

	logic [CW-1:0] den_sh;
	logic [CW-1:0] rem_r_x, rem_p_x;
	div_t          div_d;
	logic          vld_q;
	div_t          div_q;

	// Trial subtract of the shifted divisor in each lane
	always_comb begin
		den_sh  = CW'(div_in.den) << BIT;
		rem_r_x = {1'b0, div_in.rem_r};
		rem_p_x = {1'b0, div_in.rem_p};
		div_d   = div_in;
		if (rem_r_x >= den_sh) begin
			div_d.rem_r      = NW'(rem_r_x - den_sh);
			div_d.quo_r[BIT] = 1'b1;
		end
		if (rem_p_x >= den_sh) begin
			div_d.rem_p      = NW'(rem_p_x - den_sh);
			div_d.quo_p[BIT] = 1'b1;
		end
	end

	// Advance to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		div_q <= div_d;
	end

	assign vld_out = vld_q;
	assign div_out = div_q;

endmodule

@@ rtl/qmd_mix.sv @@
// Output stage: apply signs, mix through the X-frame matrix and saturate.
module qmd_mix import qmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vld_in,
	input  div_t    div_in,
	output logic    done,
	output thrust_t thrust
);

	logic signed [15:0] qr, qp, r_f, p_f;
	logic signed [17:0] rx, px, yx, tx;
	logic signed [17:0] m1, m2, m3, m4;
	thrust_t            thrust_d;
	logic               done_q;
	thrust_t            thrust_q;

	function automatic logic [14:0] sat_q(input logic signed [17:0] v);
		logic [14:0] res;
		if (v < 18'sd0) begin
			res = '0;
		end else if (v > 18'sd16384) begin
			res = Q_ONE;
		end else begin
			res = v[14:0];
		end
		return res;
	endfunction

	// Restore the signs of the scaled roll and pitch
	always_comb begin
		qr = $signed({2'b0, div_in.quo_r});
		qp = $signed({2'b0, div_in.quo_p});
		unique case (div_in.side.mode)
			MODE_SCALE: begin
				r_f = div_in.side.neg_r ? -qr : qr;
				p_f = div_in.side.neg_p ? -qp : qp;
			end
			default: begin
				r_f = div_in.side.r_pass;
				p_f = div_in.side.p_pass;
			end
		endcase
	end

	// Mix and saturate each motor
	always_comb begin
		rx = 18'(r_f);
		px = 18'(p_f);
		yx = 18'(div_in.side.y_fin);
		tx = $signed({3'b0, div_in.side.thr});
		m1 = -rx - px + yx + tx;
		m2 = -rx + px - yx + tx;
		m3 =  rx - px - yx + tx;
		m4 =  rx + px + yx + tx;
		if (div_in.side.mode == MODE_FLAT) begin
			thrust_d.motor1_thrust = div_in.side.thr;
			thrust_d.motor2_thrust = div_in.side.thr;
			thrust_d.motor3_thrust = div_in.side.thr;
			thrust_d.motor4_thrust = div_in.side.thr;
		end else begin
			thrust_d.motor1_thrust = sat_q(m1);
			thrust_d.motor2_thrust = sat_q(m2);
			thrust_d.motor3_thrust = sat_q(m3);
			thrust_d.motor4_thrust = sat_q(m4);
		end
	end

	// Hold the result for one strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		thrust_q <= thrust_d;
	end

	assign done   = done_q;
	assign thrust = thrust_q;

endmodule

@@ bench/qmd_thrust_checker.sv @@
// Checker for the motor mixer: predicts each thrust set and compares it with the DUT output.
`timescale 1ns / 100ps

module qmd_thrust_checker import qmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  cmd_t    cmd,
	input  logic    done,
	input  thrust_t thrust,
	output int      fail_count,
	output int      pending_count,
	output int      checked_count
);

	thrust_t expected_thrust_q[$];
	thrust_t oldest_thrust;
	int      mismatches = 0;
	int      checked    = 0;

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// x * num / den on magnitudes, truncated toward zero, sign put back afterwards
	function automatic int scale_toward_zero(int x, int num, int den);
		longint prod;
		int     quo;
		prod = longint'(mag(x)) * longint'(num);
		quo  = int'(prod / longint'(den));
		return (x < 0) ? -quo : quo;
	endfunction

	// Mix one request into four thrusts, roll and pitch taking priority over yaw
	function automatic thrust_t mix_expected(cmd_t c);
		int      r, p, y, t, h, s, yaw_room, yaw_mag;
		int      motor_sum [4];
		thrust_t o;
		r = clamp_int(int'(c.roll_torque),  int'(TQ_NEG), int'(TQ_POS));
		p = clamp_int(int'(c.pitch_torque), int'(TQ_NEG), int'(TQ_POS));
		y = clamp_int(int'(c.yaw_torque),   int'(TQ_NEG), int'(TQ_POS));
		t = clamp_int(int'(c.throttle), 0, int'(Q_ONE));
		h = (int'(Q_ONE) - t < t) ? int'(Q_ONE) - t : t;

		// too close to either end: every motor simply follows the throttle
		if (h < int'(MIN_HEAD)) begin
			o.motor1_thrust = 15'(t);
			o.motor2_thrust = 15'(t);
			o.motor3_thrust = 15'(t);
			o.motor4_thrust = 15'(t);
			return o;
		end

		s = mag(r) + mag(p);
		if (s > h && s >= int'(MIN_HEAD)) begin
			// shrink roll and pitch into the headroom, drop yaw
			r = scale_toward_zero(r, h, s);
			p = scale_toward_zero(p, h, s);
			y = 0;
		end else begin
			// fit yaw into what roll and pitch leave over
			yaw_room = h - s;
			yaw_mag  = mag(y);
			if (yaw_mag > yaw_room && yaw_mag >= int'(MIN_HEAD))
				y = scale_toward_zero(y, yaw_room, yaw_mag);
		end

		motor_sum[0] = -r - p + y + t;
		motor_sum[1] = -r + p - y + t;
		motor_sum[2] =  r - p - y + t;
		motor_sum[3] =  r + p + y + t;
		o.motor1_thrust = 15'(clamp_int(motor_sum[0], 0, int'(Q_ONE)));
		o.motor2_thrust = 15'(clamp_int(motor_sum[1], 0, int'(Q_ONE)));
		o.motor3_thrust = 15'(clamp_int(motor_sum[2], 0, int'(Q_ONE)));
		o.motor4_thrust = 15'(clamp_int(motor_sum[3], 0, int'(Q_ONE)));
		return o;
	endfunction

	task automatic check_field(string name, logic [14:0] want, logic [14:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Retire results against the oldest prediction, then queue any new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_thrust_q.delete();
			fail_count    <= 0;
			pending_count <= 0;
			checked_count <= 0;
		end else begin
			if (done) begin
				if (expected_thrust_q.size() == 0) begin
					$error("thrust set %h arrived with no request outstanding", thrust);
					mismatches++;
				end else begin
					oldest_thrust = expected_thrust_q.pop_front();
					check_field("motor1_thrust", oldest_thrust.motor1_thrust,
						thrust.motor1_thrust);
					check_field("motor2_thrust", oldest_thrust.motor2_thrust,
						thrust.motor2_thrust);
					check_field("motor3_thrust", oldest_thrust.motor3_thrust,
						thrust.motor3_thrust);
					check_field("motor4_thrust", oldest_thrust.motor4_thrust,
						thrust.motor4_thrust);
					checked++;
				end
			end
			if (start && !busy)
				expected_thrust_q.push_back(mix_expected(cmd));
			fail_count    <= mismatches;
			pending_count <= expected_thrust_q.size();
			checked_count <= checked;
		end
	end

endmodule

@@ bench/tb.sv @@
// Top of the motor mixer bench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module tb;
	import qmd_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 11;
	localparam int LATENCY      = 17;
	localparam int RANDOM_ITEMS = 580;
	localparam int QUIET_TAIL   = 80;
	localparam int LIMIT_CYCLES = 200000;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	thrust_t thrust;
	int      fail_count;
	int      pending_count;
	int      checked_count;

	int      requests_sent = 0;
	int      idle_bursts   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	quad_motor_mixer_desaturate dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.thrust (thrust)
	);

	qmd_thrust_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.done          (done),
		.thrust        (thrust),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	function automatic cmd_t make_cmd(int r, int p, int y, int t);
		cmd_t c;
		c.roll_torque  = 16'(r);
		c.pitch_torque = 16'(p);
		c.yaw_torque   = 16'(y);
		c.throttle     = 16'(t);
		return c;
	endfunction

	function automatic int signed_rand(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	// Random request, weighted towards the interesting corners of the mixer
	function automatic cmd_t mix_request();
		int sel, t, h, a, b;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			// raw 16-bit noise, mostly clamped
			return make_cmd($urandom, $urandom, $urandom, $urandom);
		end else if (sel < 6) begin
			return make_cmd(signed_rand(16384), signed_rand(16384), signed_rand(16384),
				$urandom_range(0, 16384));
		end else if (sel < 8) begin
			// small roll and pitch so that yaw trimming is exercised
			return make_cmd(signed_rand(2000), signed_rand(2000), signed_rand(16384),
				$urandom_range(0, 16384));
		end else if (sel < 9) begin
			// throttle near either end, around the minimum headroom
			t = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 400)
				: $urandom_range(15984, 16384);
			return make_cmd(signed_rand(400), signed_rand(400), signed_rand(400), t);
		end else begin
			// roll plus pitch within one of the headroom
			t = $urandom_range(164, 16220);
			h = (16384 - t < t) ? 16384 - t : t;
			a = $urandom_range(0, h);
			b = h - a + int'($urandom_range(0, 2)) - 1;
			if (b < 0)
				b = 0;
			if ($urandom_range(0, 1) != 0)
				a = -a;
			if ($urandom_range(0, 1) != 0)
				b = -b;
			return make_cmd(a, b, signed_rand(16384), t);
		end
	endfunction

	// Present one request and hold it until it is taken
	task automatic send_request(cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		requests_sent++;
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		idle_bursts++;
		repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	// Drop start and wait for every outstanding result
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("quad_motor_mixer_desaturate regression: fail");
		$finish;
	end

	initial begin
		cmd_t directed_q[$];
		int   n;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and each path through the mixer
		directed_q.push_back(make_cmd(0, 0, 0, 0));
		directed_q.push_back(make_cmd(32767, 32767, 32767, 32767));
		directed_q.push_back(make_cmd(-32768, -32768, -32768, -32768));
		directed_q.push_back(make_cmd(16384, -16384, 16384, 8192));
		directed_q.push_back(make_cmd(-32768, 32767, -32768, 8192));
		directed_q.push_back(make_cmd(100, 50, 10, 163));
		directed_q.push_back(make_cmd(100, 50, 10, 164));
		directed_q.push_back(make_cmd(-60, 80, -2000, 16220));
		directed_q.push_back(make_cmd(-60, 80, -2000, 16221));
		directed_q.push_back(make_cmd(3000, -2000, 5000, 8192));
		directed_q.push_back(make_cmd(3000, 2000, -1000, 8192));
		directed_q.push_back(make_cmd(200, 0, -150, 200));
		directed_q.push_back(make_cmd(-200, 0, 150, 16184));
		directed_q.push_back(make_cmd(-1, 1, -1, 4000));
		directed_q.push_back(make_cmd(-5000, -7001, 9999, 12000));
		directed_q.push_back(make_cmd(0, 0, -16384, 10000));
		directed_q.push_back(make_cmd(16383, 1, 0, 6000));
		directed_q.push_back(make_cmd(4096, -4096, 300, 8192));
		directed_q.push_back(make_cmd(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		directed_q.push_back(make_cmd(16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA));
		directed_q.push_back(make_cmd(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));

		foreach (directed_q[i]) begin
			send_request(directed_q[i]);
			if ($urandom_range(0, 3) == 0)
				idle_burst();
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// let the pipeline empty once midway
			if (n == RANDOM_ITEMS / 2)
				drain();
			send_request(mix_request());
			if (n < RANDOM_ITEMS - QUIET_TAIL && (n / 40) % 3 != 0
					&& $urandom_range(0, 3) == 0)
				idle_burst();
		end

		drain();
		repeat (LATENCY + 8) @(posedge clk);

		$display("covered %0d requests (%0d directed, %0d random), %0d idle bursts;",
			requests_sent, directed_q.size(), RANDOM_ITEMS, idle_bursts);
		$display("%0d thrust sets compared, %0d mismatching fields", checked_count,
			fail_count);
		if (fail_count == 0)
			$display("quad_motor_mixer_desaturate regression: pass");
		else
			$display("quad_motor_mixer_desaturate regression: fail");
		$finish;
	end

endmodule

@@ quad_motor_mixer_desaturate.f @@
rtl/qmd_pkg.sv
rtl/qmd_front.sv
rtl/qmd_div_cell.sv
rtl/qmd_mix.sv
rtl/quad_motor_mixer_desaturate.sv
bench/qmd_thrust_checker.sv
bench/tb.sv
